>>> rtl/bsi_pkg.sv
// ----------------------------------------------------------------------------
// bsi_pkg
// Shared types and codes for the bit-sliced index range compare core.
// ----------------------------------------------------------------------------
package bsi_pkg;

  localparam int VAL_W  = 63;
  localparam int ROW_W  = 10;
  localparam int WORD_W = 64;
  localparam int WIDX_W = 4;

  typedef logic [1:0]        opcode_t;
  typedef logic [2:0]        cmp_op_t;
  typedef logic [1:0]        status_t;
  typedef logic [VAL_W-1:0]  value_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam opcode_t OP_APPEND  = 2'd0;
  localparam opcode_t OP_COMPARE = 2'd1;
  localparam opcode_t OP_READ    = 2'd2;
  localparam opcode_t OP_NOP     = 2'd3;

  localparam cmp_op_t CMP_EQ = 3'd0;
  localparam cmp_op_t CMP_NE = 3'd1;
  localparam cmp_op_t CMP_GE = 3'd2;
  localparam cmp_op_t CMP_GT = 3'd3;
  localparam cmp_op_t CMP_LE = 3'd4;
  localparam cmp_op_t CMP_LT = 3'd5;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_ABOVE_MAX = 2'd1;
  localparam status_t ST_PRESENT   = 2'd2;
  localparam status_t ST_BELOW_MIN = 2'd3;

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  typedef struct packed {
    logic    init;
    logic    step;
    logic    lit_bit;
    cmp_op_t op;
  } walk_ctl_t;

endpackage

>>> rtl/bsi_ram.sv
// ----------------------------------------------------------------------------
// bsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bsi_walk.sv
// ----------------------------------------------------------------------------
// bsi_walk
// Slice walk unit: keeps the greater/less/equal row sets of one word and
// folds in one slice per step, then picks the requested relation.
// ----------------------------------------------------------------------------
module bsi_walk (
  input  logic              clk,
  input  bsi_pkg::walk_ctl_t ctl,
  input  bsi_pkg::word_t    ebm,
  input  bsi_pkg::word_t    slice,
  output bsi_pkg::word_t    result
);
  import bsi_pkg::*;

  word_t eq_r, gt_r, lt_r, ebm_r;
  word_t eq_nxt, gt_nxt, lt_nxt, ebm_nxt;
  word_t eqm;

  always_comb begin
    eq_nxt  = eq_r;
    gt_nxt  = gt_r;
    lt_nxt  = lt_r;
    ebm_nxt = ebm_r;
    if (ctl.init) begin
      eq_nxt  = ebm;
      gt_nxt  = '0;
      lt_nxt  = '0;
      ebm_nxt = ebm;
    end else if (ctl.step) begin
      if (ctl.lit_bit) begin
        lt_nxt = lt_r | (eq_r & ~slice);
        eq_nxt = eq_r & slice;
      end else begin
        gt_nxt = gt_r | (eq_r & slice);
        eq_nxt = eq_r & ~slice;
      end
    end
  end

  always_ff @(posedge clk) begin
    eq_r  <= eq_nxt;
    gt_r  <= gt_nxt;
    lt_r  <= lt_nxt;
    ebm_r <= ebm_nxt;
  end

  assign eqm = eq_r & ebm_r;

  always_comb begin
    case (ctl.op)
      CMP_EQ:  result = eqm;
      CMP_NE:  result = ebm_r & ~eqm;
      CMP_GE:  result = (gt_r & ebm_r) | eqm;
      CMP_GT:  result = gt_r & ebm_r;
      CMP_LE:  result = (lt_r & ebm_r) | eqm;
      CMP_LT:  result = lt_r & ebm_r;
      default: result = '0;
    endcase
  end

endmodule

>>> rtl/bit_sliced_index_range_compare_core.sv
// ----------------------------------------------------------------------------
// bit_sliced_index_range_compare_core
// Bit-sliced range index: append row values, compare against a literal,
// read the present-row bitmap. Results stream out as 64-row words.
// ----------------------------------------------------------------------------
// Each request runs a setup (row wrap, three compares on the shared 64-bit subtractor,
// then slice-count normalization); append then sets the row bit in the slice words of
// the set bits of value - min. Compare with slice walk: (ROWS+63)/64 words, one slice
// read per cycle from the single slice RAM port; read and shortcut results skip the walk.
// After reset a clearing pass over all MAX_SLICES*WORDS slice words zeroes both RAMs
// with busy high. Results are strobed; the receiver cannot stall.
module bit_sliced_index_range_compare_core #(
  parameter int ROWS       = 1024,
  parameter int MAX_SLICES = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bsi_pkg::opcode_t  in_opcode,
  input  logic [9:0]        in_row_id,
  input  bsi_pkg::value_t   in_operand_value,
  input  bsi_pkg::cmp_op_t  in_compare_op,
  output logic              out_valid,
  output bsi_pkg::status_t  out_status,
  output logic [3:0]        out_word_index,
  output bsi_pkg::word_t    out_row_bits,
  output logic              out_last_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  bsi_pkg::value_t   cfg_data
);
  import bsi_pkg::*;

  localparam int WORDS = (ROWS + 63) / 64;
  localparam int PAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SD    = MAX_SLICES * WORDS;
  localparam int SAW   = (SD > 1) ? $clog2(SD) : 1;
  localparam int NSW   = $clog2(MAX_SLICES + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRAP, S_CMP_MM, S_CMP_LMN, S_CMP_LMX, S_NORM, S_DISP,
    S_A_CHK, S_A_RD, S_A_WR, S_Q_RD, S_Q_INIT, S_Q_STEP, S_Q_FIN
  } state_t;

  typedef enum logic [1:0] {MODE_PRES, MODE_ZERO, MODE_WALK} mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  value_t              min_r, min_nxt, max_r, max_nxt, val_r, val_nxt;
  opcode_t             opc_r, opc_nxt;
  cmp_op_t             cop_r, cop_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [SAW-1:0]      clr_r, clr_nxt, sa_r, sa_nxt, top_r, top_nxt;
  logic [PAW-1:0]      w_r, w_nxt;
  logic [NSW-1:0]      ns_r, ns_nxt, k_r, k_nxt;
  logic [MAX_SLICES-1:0] sp_r, sp_nxt, rel_r, rel_nxt, al_r, al_nxt;
  logic [MAX_SLICES-1:0] ap_r, ap_nxt, wl_r, wl_nxt;
  logic                hi_r, hi_nxt;
  logic                mm_eq_r, mm_eq_nxt, lm_lt_r, lm_lt_nxt, lm_eq_r, lm_eq_nxt;
  logic                lx_lt_r, lx_lt_nxt, lx_eq_r, lx_eq_nxt;
  word_t               pw_r, pw_nxt;

  logic                out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [WIDX_W-1:0]   out_widx_r, out_widx_nxt;
  word_t               out_bits_r, out_bits_nxt;

  logic                p_we, s_we;
  logic [PAW-1:0]      p_waddr, p_raddr, rw;
  logic [SAW-1:0]      s_waddr, s_raddr;
  word_t               p_wdata, s_wdata, p_rdata, s_rdata, wres, row_bit;
  walk_ctl_t           wctl;

  value_t              cmp_a, cmp_b;
  logic [VAL_W:0]      diff;
  logic                diff_zero;
  value_t              span;
  logic                sc_all, sc_none, lit_le_mn, lit_gt_mx, lit_ge_mx, last_w;

  bsi_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_present (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  bsi_ram #(.WIDTH(WORD_W), .DEPTH(SD)) u_slices (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  bsi_walk u_walk (
    .clk(clk), .ctl(wctl), .ebm(p_rdata), .slice(s_rdata), .result(wres)
  );

  // shared subtract/compare unit
  always_comb begin
    case (state_r)
      S_CMP_MM: begin
        cmp_a = max_r;
        cmp_b = min_r;
      end
      S_CMP_LMX: begin
        cmp_a = val_r;
        cmp_b = max_r;
      end
      default: begin
        cmp_a = val_r;
        cmp_b = min_r;
      end
    endcase
    diff      = {1'b0, cmp_a} - {1'b0, cmp_b};
    diff_zero = (diff == '0);
    span      = diff[VAL_W] ? '0 : diff[VAL_W-1:0];
  end

  // min/max shortcut
  always_comb begin
    lit_le_mn = lm_lt_r | lm_eq_r;
    lit_gt_mx = !lx_lt_r && !lx_eq_r;
    lit_ge_mx = !lx_lt_r;
    sc_all    = 1'b0;
    sc_none   = 1'b0;
    case (cop_r)
      CMP_EQ: begin
        sc_all  = mm_eq_r && lm_eq_r;
        sc_none = !sc_all && (lm_lt_r || lit_gt_mx);
      end
      CMP_NE: begin
        sc_none = mm_eq_r && lm_eq_r;
        sc_all  = !sc_none && (lm_lt_r || lit_gt_mx);
      end
      CMP_GE: begin
        sc_all  = lit_le_mn;
        sc_none = !sc_all && lit_gt_mx;
      end
      CMP_GT: begin
        sc_all  = lm_lt_r;
        sc_none = !sc_all && lit_ge_mx;
      end
      CMP_LE: begin
        sc_all  = lit_ge_mx;
        sc_none = !sc_all && lm_lt_r;
      end
      CMP_LT: begin
        sc_all  = lit_gt_mx;
        sc_none = !sc_all && lit_le_mn;
      end
      default: sc_none = 1'b1;
    endcase
  end

  assign rw      = PAW'(row_r >> 6);
  assign row_bit = word_t'(1) << row_r[5:0];
  assign last_w  = (w_r == PAW'(WORDS - 1));

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    val_nxt        = val_r;
    opc_nxt        = opc_r;
    cop_nxt        = cop_r;
    row_nxt        = row_r;
    clr_nxt        = clr_r;
    sa_nxt         = sa_r;
    top_nxt        = top_r;
    w_nxt          = w_r;
    ns_nxt         = ns_r;
    k_nxt          = k_r;
    sp_nxt         = sp_r;
    rel_nxt        = rel_r;
    al_nxt         = al_r;
    ap_nxt         = ap_r;
    wl_nxt         = wl_r;
    hi_nxt         = hi_r;
    mm_eq_nxt      = mm_eq_r;
    lm_lt_nxt      = lm_lt_r;
    lm_eq_nxt      = lm_eq_r;
    lx_lt_nxt      = lx_lt_r;
    lx_eq_nxt      = lx_eq_r;
    pw_nxt         = pw_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_widx_nxt   = out_widx_r;
    out_bits_nxt   = out_bits_r;
    out_last_nxt   = out_last_r;
    p_we           = 1'b0;
    p_waddr        = rw;
    p_wdata        = '0;
    p_raddr        = w_r;
    s_we           = 1'b0;
    s_waddr        = sa_r;
    s_wdata        = '0;
    s_raddr        = sa_r;
    wctl           = '{init: 1'b0, step: 1'b0, lit_bit: wl_r[MAX_SLICES-1], op: cop_r};

    if (cfg_valid) begin
      if (cfg_index == CFG_MIN) begin
        min_nxt = cfg_data;
      end else begin
        max_nxt = cfg_data;
      end
    end

    case (state_r)
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
        p_waddr = PAW'(clr_r);
        p_we    = ({1'b0, clr_r} < (SAW+1)'(WORDS));
        if (clr_r == SAW'(SD - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          opc_nxt   = in_opcode;
          row_nxt   = in_row_id;
          val_nxt   = in_operand_value;
          cop_nxt   = in_compare_op;
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        if ({7'd0, row_r} >= 17'(ROWS)) begin
          row_nxt = row_r - ROW_W'(ROWS);
        end else begin
          state_nxt = S_CMP_MM;
        end
      end
      S_CMP_MM: begin
        sp_nxt    = span[MAX_SLICES-1:0];
        hi_nxt    = ((64'(span) >> MAX_SLICES) != 64'd0);
        mm_eq_nxt = diff_zero;
        state_nxt = S_CMP_LMN;
      end
      S_CMP_LMN: begin
        lm_lt_nxt = diff[VAL_W];
        lm_eq_nxt = diff_zero;
        rel_nxt   = diff[MAX_SLICES-1:0];
        state_nxt = S_CMP_LMX;
      end
      S_CMP_LMX: begin
        lx_lt_nxt = diff[VAL_W];
        lx_eq_nxt = diff_zero;
        ns_nxt    = NSW'(MAX_SLICES);
        al_nxt    = rel_r;
        top_nxt   = SAW'(SD - WORDS);
        state_nxt = hi_r ? S_DISP : S_NORM;
      end
      S_NORM: begin
        if (ns_r != '0 && !sp_r[MAX_SLICES-1]) begin
          ns_nxt  = ns_r - 1'b1;
          sp_nxt  = sp_r << 1;
          al_nxt  = al_r << 1;
          top_nxt = top_r - SAW'(WORDS);
        end else begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        w_nxt = '0;
        case (opc_r)
          OP_APPEND: begin
            if (!lx_lt_r && !lx_eq_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_ABOVE_MAX;
              out_widx_nxt   = '0;
              out_bits_nxt   = '0;
              out_last_nxt   = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              p_raddr   = rw;
              state_nxt = S_A_CHK;
            end
          end
          OP_COMPARE: begin
            mode_nxt  = sc_all ? MODE_PRES : (sc_none ? MODE_ZERO : MODE_WALK);
            state_nxt = S_Q_RD;
          end
          OP_READ: begin
            mode_nxt  = MODE_PRES;
            state_nxt = S_Q_RD;
          end
          default: begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_widx_nxt   = '0;
            out_bits_nxt   = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        endcase
      end
      S_A_CHK: begin
        pw_nxt = p_rdata;
        if ((p_rdata & row_bit) != '0 || lm_lt_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ((p_rdata & row_bit) != '0) ? ST_PRESENT : ST_BELOW_MIN;
          out_widx_nxt   = '0;
          out_bits_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          k_nxt     = ns_r;
          sa_nxt    = SAW'(rw);
          ap_nxt    = rel_r;
          state_nxt = S_A_RD;
        end
      end
      S_A_RD: begin
        if (k_r == '0) begin
          p_we           = 1'b1;
          p_wdata        = pw_r | row_bit;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_widx_nxt   = '0;
          out_bits_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else if (ap_r[0]) begin
          state_nxt = S_A_WR;
        end else begin
          k_nxt  = k_r - 1'b1;
          sa_nxt = sa_r + SAW'(WORDS);
          ap_nxt = ap_r >> 1;
        end
      end
      S_A_WR: begin
        s_we      = 1'b1;
        s_wdata   = s_rdata | row_bit;
        k_nxt     = k_r - 1'b1;
        sa_nxt    = sa_r + SAW'(WORDS);
        ap_nxt    = ap_r >> 1;
        state_nxt = S_A_RD;
      end
      S_Q_RD: begin
        sa_nxt    = top_r + SAW'(w_r);
        k_nxt     = ns_r;
        wl_nxt    = al_r;
        state_nxt = S_Q_INIT;
      end
      S_Q_INIT: begin
        if (mode_r == MODE_WALK) begin
          wctl.init = 1'b1;
          state_nxt = (k_r == '0) ? S_Q_FIN : S_Q_STEP;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_widx_nxt   = WIDX_W'(w_r);
          out_bits_nxt   = (mode_r == MODE_PRES) ? p_rdata : '0;
          out_last_nxt   = last_w;
          if (last_w) begin
            state_nxt = S_IDLE;
          end else begin
            w_nxt     = w_r + 1'b1;
            state_nxt = S_Q_RD;
          end
        end
      end
      S_Q_STEP: begin
        wctl.step = 1'b1;
        s_raddr   = sa_r - SAW'(WORDS);
        sa_nxt    = sa_r - SAW'(WORDS);
        wl_nxt    = wl_r << 1;
        k_nxt     = k_r - 1'b1;
        if (k_r == NSW'(1)) begin
          state_nxt = S_Q_FIN;
        end
      end
      S_Q_FIN: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_widx_nxt   = WIDX_W'(w_r);
        out_bits_nxt   = wres;
        out_last_nxt   = last_w;
        if (last_w) begin
          state_nxt = S_IDLE;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_Q_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    val_r        <= val_nxt;
    opc_r        <= opc_nxt;
    cop_r        <= cop_nxt;
    row_r        <= row_nxt;
    sa_r         <= sa_nxt;
    top_r        <= top_nxt;
    w_r          <= w_nxt;
    ns_r         <= ns_nxt;
    k_r          <= k_nxt;
    sp_r         <= sp_nxt;
    rel_r        <= rel_nxt;
    al_r         <= al_nxt;
    ap_r         <= ap_nxt;
    wl_r         <= wl_nxt;
    hi_r         <= hi_nxt;
    mm_eq_r      <= mm_eq_nxt;
    lm_lt_r      <= lm_lt_nxt;
    lm_eq_r      <= lm_eq_nxt;
    lx_lt_r      <= lx_lt_nxt;
    lx_eq_r      <= lx_eq_nxt;
    pw_r         <= pw_nxt;
    out_status_r <= out_status_nxt;
    out_widx_r   <= out_widx_nxt;
    out_bits_r   <= out_bits_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_word_index = out_widx_r;
  assign out_row_bits   = out_bits_r;
  assign out_last_word  = out_last_r;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bit_sliced_index_range_compare_core. A short table
// of requests covers the bound checks, each relation, the shortcuts and the
// unused codes. Random phases follow under several min/max settings and idle
// patterns. Each successful append updates a local copy of the index, and
// every result word is checked against the queue of predicted words.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsi_pkg::*;

  localparam int WORDS = 16;
  localparam int SLICES = 63;
  localparam int PHASE_ITEMS = 82;
  localparam value_t VMAX = '1;

  typedef enum int {SC_NONE, SC_ALL, SC_WALK} shortcut_t;

  typedef struct packed {
    opcode_t    op;
    logic [9:0] row;
    value_t     val;
    cmp_op_t    cmp;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] widx;
    word_t      bits;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       cfg;
    opcode_t    op;
    logic [9:0] row;
    value_t     val;
    value_t     hi;
    cmp_op_t    cmp;
    logic       typed;
    status_t    t_status;
    word_t      t_bits;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  opcode_t    in_opcode;
  logic [9:0] in_row_id;
  value_t     in_operand_value;
  cmp_op_t    in_compare_op;
  logic       out_valid;
  status_t    out_status;
  logic [3:0] out_word_index;
  word_t      out_row_bits;
  logic       out_last_word;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  value_t     cfg_data;

  // local copy of the index
  word_t  present_map [WORDS] = '{default: '0};
  word_t  slice_map [SLICES][WORDS] = '{default: '{default: '0}};
  value_t lo_bound = '0;
  value_t hi_bound = '0;
  value_t stored_vals [$];

  res_t pending_words [$];
  int   mismatches = 0;

  bit_sliced_index_range_compare_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_row_id        (in_row_id),
    .in_operand_value (in_operand_value),
    .in_compare_op    (in_compare_op),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_word_index   (out_word_index),
    .out_row_bits     (out_row_bits),
    .out_last_word    (out_last_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic value_t rand63();
    return value_t'({$urandom, $urandom});
  endfunction

  function automatic value_t rand_in(value_t lo, value_t hi);
    logic [63:0] span;
    span = {1'b0, hi - lo} + 64'd1;
    return lo + value_t'({$urandom, $urandom} % span);
  endfunction

  function automatic int slice_count();
    value_t span;
    int n = 0;
    if (hi_bound < lo_bound) return 0;
    span = hi_bound - lo_bound;
    for (int i = 0; i < SLICES; i++) if (span[i]) n = i + 1;
    return n;
  endfunction

  function automatic shortcut_t shortcut(cmp_op_t op, value_t lit);
    value_t mn = lo_bound;
    value_t mx = hi_bound;
    case (op)
      CMP_EQ: begin
        if (mn == mx && mn == lit) return SC_ALL;
        if (lit < mn || lit > mx) return SC_NONE;
      end
      CMP_NE: begin
        if (mn == mx && mn == lit) return SC_NONE;
        if (lit < mn || lit > mx) return SC_ALL;
      end
      CMP_GE: begin
        if (lit <= mn) return SC_ALL;
        if (lit > mx) return SC_NONE;
      end
      CMP_GT: begin
        if (lit < mn) return SC_ALL;
        if (lit >= mx) return SC_NONE;
      end
      CMP_LE: begin
        if (lit >= mx) return SC_ALL;
        if (lit < mn) return SC_NONE;
      end
      CMP_LT: begin
        if (lit > mx) return SC_ALL;
        if (lit <= mn) return SC_NONE;
      end
      default: return SC_NONE;
    endcase
    return SC_WALK;
  endfunction

  // top slice down, tracking greater / less / equal row sets
  function automatic word_t walk_word(cmp_op_t op, value_t rel, int w, int ns);
    word_t ebm = present_map[w];
    word_t eq = present_map[w];
    word_t gt = '0;
    word_t lt = '0;
    word_t s;
    for (int i = ns - 1; i >= 0; i--) begin
      s = slice_map[i][w];
      if (rel[i]) begin
        lt |= eq & ~s;
        eq &= s;
      end else begin
        gt |= eq & s;
        eq &= ~s;
      end
    end
    eq &= ebm;
    case (op)
      CMP_EQ: return eq;
      CMP_NE: return ebm & ~eq;
      CMP_GE: return (gt & ebm) | eq;
      CMP_GT: return gt & ebm;
      CMP_LE: return (lt & ebm) | eq;
      CMP_LT: return lt & ebm;
      default: return '0;
    endcase
  endfunction

  function automatic void predict(req_t r, logic typed, status_t ts, word_t tb);
    res_t words [$];
    res_t one;
    shortcut_t sc;
    word_t bits;
    int ns;
    value_t rel;
    logic [3:0] rw;
    logic [5:0] rb;
    ns = slice_count();
    rel = r.val - lo_bound;
    rw = r.row[9:6];
    rb = r.row[5:0];
    case (r.op)
      OP_APPEND: begin
        one = res_t'{ST_OK, 4'd0, '0, 1'b1};
        if (r.val > hi_bound) begin
          one.status = ST_ABOVE_MAX;
        end else if (present_map[rw][rb]) begin
          one.status = ST_PRESENT;
        end else if (r.val < lo_bound) begin
          one.status = ST_BELOW_MIN;
        end else begin
          for (int i = 0; i < ns; i++) if (rel[i]) slice_map[i][rw][rb] = 1'b1;
          present_map[rw][rb] = 1'b1;
          stored_vals.push_back(r.val);
        end
        words.push_back(one);
      end
      OP_COMPARE: begin
        sc = shortcut(r.cmp, r.val);
        for (int w = 0; w < WORDS; w++) begin
          case (sc)
            SC_ALL:  bits = present_map[w];
            SC_NONE: bits = '0;
            default: bits = walk_word(r.cmp, rel, w, ns);
          endcase
          words.push_back(res_t'{ST_OK, 4'(w), bits, w == WORDS - 1});
        end
      end
      OP_READ: begin
        for (int w = 0; w < WORDS; w++)
          words.push_back(res_t'{ST_OK, 4'(w), present_map[w], w == WORDS - 1});
      end
      default: words.push_back(res_t'{ST_OK, 4'd0, '0, 1'b1});
    endcase
    foreach (words[k]) begin
      one = words[k];
      if (typed) begin
        one.status = ts;
        one.bits = tb;
      end
      pending_words.push_back(one);
    end
  endfunction

  task automatic issue(req_t r, logic typed, status_t ts, word_t tb, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_opcode        <= r.op;
    in_row_id        <= r.row;
    in_operand_value <= r.val;
    in_compare_op    <= r.cmp;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    predict(r, typed, ts, tb);
    @(negedge clk);
  endtask

  // bounds change only with the core drained
  task automatic set_bounds(value_t lo, value_t hi);
    start <= 1'b0;
    do @(negedge clk); while (pending_words.size() != 0 || busy);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MIN;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    lo_bound = lo;
    @(negedge clk);
    cfg_index <= CFG_MAX;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    hi_bound = hi;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_words
    res_t got;
    res_t want;
    if (rst_n && out_valid) begin
      got = res_t'{out_status, out_word_index, out_row_bits, out_last_word};
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: status %0d idx %0d bits %h last %b", $time,
                 got.status, got.widx, got.bits, got.last);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (got.status !== want.status || got.widx !== want.widx ||
            got.bits !== want.bits || got.last !== want.last) begin
          $display("%0t: mismatch: expected status %0d idx %0d bits %h last %b", $time,
                   want.status, want.widx, want.bits, want.last);
          $display("%0t:           actual   status %0d idx %0d bits %h last %b", $time,
                   got.status, got.widx, got.bits, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_tab [$];
    int idle_sched [5] = '{0, 83, 0, 36, 83};
    req_t r;
    value_t lo;
    value_t hi;
    int pick;
    int v;

    start = 1'b0;
    in_opcode = OP_NOP;
    in_row_id = '0;
    in_operand_value = '0;
    in_compare_op = CMP_EQ;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN;
    cfg_data = '0;
    rst_n = 1'b0;

    // bounds at reset: min = max = 0
    dir_tab.push_back(dir_row_t'{0, OP_READ, 10'd0, 63'd0, 63'd0, CMP_EQ, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd0, 63'd0, CMP_EQ, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd5, 63'd0, 63'd0, CMP_EQ, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd5, 63'd0, 63'd0, CMP_EQ, 1, ST_PRESENT, '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd6, 63'd1, 63'd0, CMP_EQ, 1, ST_ABOVE_MAX,
                                 '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd0, 63'd0, CMP_EQ, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd0, 63'd0, CMP_NE, 1, ST_OK, '0});
    // ten slices
    dir_tab.push_back(dir_row_t'{1, OP_NOP, 10'd0, 63'd100, 63'd1123, CMP_EQ, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd0, 63'd100, 63'd0, CMP_EQ, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd1023, 63'd1123, 63'd0, CMP_EQ, 1, ST_OK,
                                 '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd7, 63'd99, 63'd0, CMP_EQ, 1, ST_BELOW_MIN,
                                 '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd0, VMAX, 63'd0, CMP_EQ, 1, ST_ABOVE_MAX,
                                 '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd0, 63'd50, 63'd0, CMP_EQ, 1, ST_PRESENT,
                                 '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd64, 63'd611, 63'd0, CMP_EQ, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd611, 63'd0, CMP_EQ, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd611, 63'd0, CMP_NE, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd611, 63'd0, CMP_GE, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd611, 63'd0, CMP_GT, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd611, 63'd0, CMP_LE, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd611, 63'd0, CMP_LT, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd611, 63'd0, 3'd6, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_NOP, 10'd1023, VMAX, 63'd0, 3'd7, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd0, 63'd0, CMP_LT, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, VMAX, 63'd0, CMP_GE, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_READ, 10'd0, 63'd0, 63'd0, CMP_EQ, 0, ST_OK, '0});
    // full range, all slices in use
    dir_tab.push_back(dir_row_t'{1, OP_NOP, 10'd0, 63'd0, VMAX, CMP_EQ, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd100, VMAX, 63'd0, CMP_EQ, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd101, 63'd0, 63'd0, CMP_EQ, 1, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, VMAX - 63'd1, 63'd0, CMP_GT, 0, ST_OK,
                                 '0});
    // min above max
    dir_tab.push_back(dir_row_t'{1, OP_NOP, 10'd0, 63'd500, 63'd400, CMP_EQ, 0, ST_OK, '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd200, 63'd450, 63'd0, CMP_EQ, 1,
                                 ST_ABOVE_MAX, '0});
    dir_tab.push_back(dir_row_t'{0, OP_APPEND, 10'd201, 63'd300, 63'd0, CMP_EQ, 1,
                                 ST_BELOW_MIN, '0});
    dir_tab.push_back(dir_row_t'{0, OP_COMPARE, 10'd0, 63'd450, 63'd0, CMP_EQ, 0, ST_OK, '0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].cfg) begin
        set_bounds(dir_tab[k].val, dir_tab[k].hi);
      end else begin
        r = req_t'{dir_tab[k].op, dir_tab[k].row, dir_tab[k].val, dir_tab[k].cmp};
        issue(r, dir_tab[k].typed, dir_tab[k].t_status, dir_tab[k].t_bits, 0);
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          lo = '0;
          hi = 63'd15;
        end
        1: begin
          lo = value_t'($urandom_range(5000));
          hi = lo + value_t'($urandom_range(1 << 20, 1));
        end
        2: begin
          lo = rand63() | {1'b1, 62'd0};
          hi = VMAX;
        end
        3: begin
          lo = rand63();
          hi = lo;
        end
        default: begin
          lo = value_t'($urandom_range(100));
          hi = lo + ((value_t'(1) << $urandom_range(40, 1)) - 63'd1);
        end
      endcase
      set_bounds(lo, hi);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        v = $urandom_range(9);
        r.row = 10'($urandom_range(1023));
        r.cmp = ($urandom_range(19) == 0) ? cmp_op_t'($urandom_range(7, 6))
                                          : cmp_op_t'($urandom_range(5));
        r.val = rand63();
        if (pick < 45) begin
          r.op = OP_APPEND;
          if (v < 8) r.val = rand_in(lo, hi);
          else if (v == 8) r.val = lo - 63'd1;
        end else if (pick < 85) begin
          r.op = OP_COMPARE;
          if (v < 5) begin
            r.val = rand_in(lo, hi);
          end else if (v < 7 && stored_vals.size() != 0) begin
            r.val = stored_vals[$urandom_range(stored_vals.size() - 1)];
          end else if (v < 8) begin
            case ($urandom_range(3))
              0: r.val = lo;
              1: r.val = hi;
              2: r.val = lo - 63'd1;
              default: r.val = hi + 63'd1;
            endcase
          end
        end else if (pick < 95) begin
          r.op = OP_READ;
        end else begin
          r.op = OP_NOP;
        end
        issue(r, 1'b0, ST_OK, '0, idle_sched[ph]);
      end
    end

    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
